/* rtl/core/tkls_pkg.sv */
// shared types and constants for the top-k largest select unit
// no dependencies; imported by every module of the block
`default_nettype none

package tkls_pkg;

  // list depth default, value and field widths
  localparam int TKLS_MAX_K      = 64;
  localparam int VALUE_W         = 32;
  localparam int RANK_W          = 6;
  localparam int TOP_COUNT_W     = 7;
  localparam int TOP_COUNT_RESET = 4;

  // configuration port
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  // input word
  typedef struct packed {
    logic signed [VALUE_W-1:0] sample;
    logic                      set_end;
  } in_word_t;

  // output word
  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic [RANK_W-1:0]         rank;
    logic                      final_result;
  } out_word_t;

  // commands from the controller to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } chain_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/tkls_cell.sv */
// one cell of the sorted chain: holds one kept value and its valid bit
// depends on tkls_pkg
`default_nettype none

module tkls_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  tkls_pkg::chain_cmd_t               cmd,
  input  logic signed [tkls_pkg::VALUE_W-1:0] new_value,
  input  logic signed [tkls_pkg::VALUE_W-1:0] prev_value,
  input  logic                               prev_valid,
  input  logic                               prev_ins,
  input  logic signed [tkls_pkg::VALUE_W-1:0] next_value,
  input  logic                               next_valid,
  output logic signed [tkls_pkg::VALUE_W-1:0] value,
  output logic                               valid,
  output logic                               ins
);
  import tkls_pkg::*;

  // new value belongs here or above: empty slot, or strictly larger than ours
  assign ins = !valid || (new_value > value);

  // valid bit: insert moves down from the neighbor, drain moves up
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      if (prev_ins) begin
        valid <= prev_valid;
      end else if (ins) begin
        valid <= 1'b1;
      end
    end else if (cmd.shift) begin
      valid <= next_valid;
    end
  end

  // held value, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (prev_ins) begin
        value <= prev_value;
      end else if (ins) begin
        value <= new_value;
      end
    end else if (cmd.shift) begin
      value <= next_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tkls_ctrl.sv */
// controller: kept count, result count and drain sequencing for the chain
// depends on tkls_pkg
`default_nettype none

module tkls_ctrl #(
  parameter int MAX_K = tkls_pkg::TKLS_MAX_K
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               set_end,
  input  logic [tkls_pkg::TOP_COUNT_W-1:0]   top_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tkls_pkg::RANK_W-1:0]        rank,
  output logic                               final_result,
  output tkls_pkg::chain_cmd_t               cmd
);
  import tkls_pkg::*;

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam logic [CNT_W-1:0]       MAX_CNT = CNT_W'(MAX_K);
  localparam logic [TOP_COUNT_W-1:0] MAX_TOP = TOP_COUNT_W'(MAX_K);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] emit_n;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] kept_inc;
  logic [CNT_W-1:0] emit_new;
  logic             in_fire;
  logic             out_fire;

  // handshakes
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DRAIN);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // clamp k into 1..MAX_K
  always_comb begin
    if (top_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (top_count > MAX_TOP) begin
      k_eff = MAX_CNT;
    end else begin
      k_eff = top_count[CNT_W-1:0];
    end
  end

  // count after this insert, saturating at a full list
  assign kept_inc = (kept == MAX_CNT) ? kept : kept + CNT_W'(1);
  assign emit_new = (kept_inc < k_eff) ? kept_inc : k_eff;

  // result side fields
  assign rank         = RANK_W'(idx);
  assign final_result = ((idx + CNT_W'(1)) == emit_n);

  // chain commands
  assign cmd.insert = in_fire;
  assign cmd.shift  = out_fire;
  assign cmd.clear  = out_fire && final_result;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      kept   <= '0;
      emit_n <= '0;
      idx    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            kept <= kept_inc;
            if (set_end) begin
              state  <= ST_DRAIN;
              emit_n <= emit_new;
              idx    <= '0;
            end
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            if (final_result) begin
              state <= ST_IDLE;
              kept  <= '0;
            end else begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (idx < emit_n) && (emit_n != '0))
    else $error("drain index beyond result count");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (out_fire && final_result) |=> (state == ST_IDLE) && (kept == '0))
    else $error("last result did not clear the list");

  a_end_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (in_fire && set_end) |=> out_valid && (idx == '0))
    else $error("set end did not start result drain");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept <= MAX_CNT)
    else $error("kept count above list depth");

endmodule

`default_nettype wire

/* rtl/core/top_k_largest_select_unit.sv */
// top level of the top-k largest select unit: register port, controller, cell chain
// depends on tkls_pkg, tkls_ctrl, tkls_cell
`default_nettype none

// Reports the K largest signed values of a set, largest first. Each input word
// carries one value; the word with set_end high closes the set. Each value is
// compared in parallel against all MAX_K cells of a sorted chain and each cell
// either keeps its value, takes the new one or takes its upper neighbor's, so a
// new value can be taken every cycle outside the drain. After the closing word of a
// set of N values the unit delivers min(N, K, MAX_K) result words, one per cycle
// while out_ready is high, the first cell shifting up the chain after each; in_ready
// is low during that drain. K is the top_count register (address 0, reset 4; 0 acts
// as 1, above MAX_K as MAX_K) and is sampled when the closing word is accepted. The
// list is empty again after the last result word, marked by final_result.
module top_k_largest_select_unit #(
  parameter int MAX_K = tkls_pkg::TKLS_MAX_K
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tkls_pkg::in_word_t                in_word,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output tkls_pkg::out_word_t               out_word,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tkls_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tkls_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tkls_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import tkls_pkg::*;

  logic [TOP_COUNT_W-1:0]     top_count;
  chain_cmd_t                 cmd;
  logic signed [VALUE_W-1:0]  cell_value [MAX_K];
  logic                       cell_valid [MAX_K];
  logic                       cell_ins   [MAX_K];
  logic                       cfg_write;

  // register port; top_count is the only register, at address 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_W'(TOP_COUNT_RESET);
    end else if (cfg_write && (paddr == '0)) begin
      top_count <= pwdata[TOP_COUNT_W-1:0];
    end
  end

  assign prdata = APB_DATA_W'(top_count);

  // controller
  tkls_ctrl #(
    .MAX_K (MAX_K)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .set_end      (in_word.set_end),
    .top_count    (top_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rank         (out_word.rank),
    .final_result (out_word.final_result),
    .cmd          (cmd)
  );

  // sorted chain, largest at cell 0
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_value;
    logic                      prev_valid;
    logic                      prev_ins;
    logic signed [VALUE_W-1:0] next_value;
    logic                      next_valid;

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_valid = 1'b0;
      assign prev_ins   = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ins   = cell_ins[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    tkls_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_value  (in_word.sample),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .prev_ins   (prev_ins),
      .next_value (next_value),
      .next_valid (next_valid),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .ins        (cell_ins[i])
    );
  end

  // head of the chain is the current result
  assign out_word.top_value = cell_value[0];

endmodule

`default_nettype wire
